// ===== hdl/pta_pkg.sv =====
// Types and codes shared by the peer table files.
`timescale 1ns / 1ps
package pta_pkg;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_SEEN   = 3'd2;
	localparam logic [2:0] OP_SEND   = 3'd3;
	localparam logic [2:0] OP_SWEEP  = 3'd4;
	localparam logic [2:0] OP_LOOKUP = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_DISABLED = 2'd3;

	localparam logic REG_ENABLED = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [31:0] RESET_TIMEOUT = 32'd30000;

	typedef struct packed {
		logic [47:0] mac;
		logic [7:0]  dev;
		logic [31:0] last_seen;
		logic [7:0]  sig;
		logic [31:0] rx;
		logic [31:0] tx;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic        hit;
		logic [7:0]  peer_device_id;
		logic [31:0] received_count;
		logic [31:0] sent_count;
		logic [47:0] evicted_mac;
		logic        evicted;
		logic [4:0]  active_peers;
		logic [31:0] failure_total;
		logic        last;
	} result_t;

endpackage

// ===== hdl/pta_if.sv =====
// Handshake channels for peer table operations and results.
`timescale 1ns / 1ps
interface pta_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [47:0] peer_mac;
	logic [7:0]  device_id;
	logic signed [7:0] signal_strength;
	logic        send_ok;
	logic [31:0] now_ms;

	modport source (output valid, operation, peer_mac, device_id, signal_strength, send_ok,
		now_ms, input ready);
	modport sink (input valid, operation, peer_mac, device_id, signal_strength, send_ok,
		now_ms, output ready);
endinterface

interface pta_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  slot;
	logic        hit;
	logic [7:0]  peer_device_id;
	logic [31:0] received_count;
	logic [31:0] sent_count;
	logic [47:0] evicted_mac;
	logic        evicted;
	logic [4:0]  active_peers;
	logic [31:0] failure_total;
	logic        last;

	modport source (output valid, status, slot, hit, peer_device_id, received_count,
		sent_count, evicted_mac, evicted, active_peers, failure_total, last, input ready);
	modport sink (input valid, status, slot, hit, peer_device_id, received_count,
		sent_count, evicted_mac, evicted, active_peers, failure_total, last, output ready);
endinterface

// ===== hdl/pta_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module pta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/peer_table_with_aging.sv =====
// Peer table top level: sequencer that scans the entry RAM for each operation.
// Each operation walks the table one slot at a time, a RAM read step then a compare
// and write-back step per slot, stopping at the first match; a miss or a sweep
// covers every slot, and a sweep stops to send a result for each evicted entry.
// Add, remove and sweep while disabled, failed sends and unused codes answer
// without a table scan. Valid bits are flip-flops cleared at reset, so the table
// is usable right after reset with no clearing pass.
`timescale 1ns / 1ps
module peer_table_with_aging
	import pta_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	pta_in_if.sink      in,
	pta_out_if.source   out
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]  state_q, state_n;
	logic        enabled_q;
	logic [31:0] timeout_q;
	logic [TABLE_ENTRIES-1:0] valid_q, valid_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [31:0] fail_q, fail_n;
	logic [IW-1:0] ptr_q, ptr_n;
	logic        more_q, more_n;
	logic        done_q, done_n;
	logic        free_q, free_n;
	logic [IW-1:0] free_idx_q, free_idx_n;
	logic [7:0]  free_sig_q, free_sig_n;
	logic [2:0]  op_q;
	logic [47:0] mac_q;
	logic [7:0]  dev_q;
	logic [7:0]  sig_q;
	logic [31:0] now_q;
	result_t     res_q, res_n;
	logic        res_load;

	logic        ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t      ram_wdata, rd;

	logic        cur_valid, match, last_slot, expired;
	logic [31:0] idle;

	pta_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES), .AW(IW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (rd)
	);

	assign cur_valid = valid_q[ptr_q];
	assign match     = cur_valid && (rd.mac == mac_q);
	assign last_slot = (ptr_q == LAST_IDX);
	assign idle      = now_q - rd.last_seen;
	assign expired   = cur_valid && (idle > timeout_q);

	assign in.ready = (state_q == S_IDLE);

	always_comb begin
		state_n    = state_q;
		valid_n    = valid_q;
		cnt_n      = cnt_q;
		fail_n     = fail_q;
		ptr_n      = ptr_q;
		more_n     = more_q;
		done_n     = done_q;
		free_n     = free_q;
		free_idx_n = free_idx_q;
		free_sig_n = free_sig_q;
		res_n      = '0;
		res_n.status = ST_OK;
		res_n.last = 1'b1;
		res_load   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = ptr_q;
		ram_wdata  = rd;

		unique case (state_q)
			S_IDLE: begin
				if (in.valid) begin
					ptr_n  = '0;
					free_n = 1'b0;
					more_n = 1'b0;
					done_n = 1'b0;
					if (!enabled_q && (in.operation == OP_ADD ||
						in.operation == OP_REMOVE || in.operation == OP_SWEEP)) begin
						res_n.status = ST_DISABLED;
						res_load = 1'b1;
						state_n = S_OUT;
					end else if (in.operation == OP_SEND && !in.send_ok) begin
						fail_n = fail_q + 32'd1;
						res_load = 1'b1;
						state_n = S_OUT;
					end else if (in.operation > OP_LOOKUP) begin
						res_load = 1'b1;
						state_n = S_OUT;
					end else begin
						state_n = S_RD;
					end
				end
			end
			S_RD: begin
				state_n = S_CMP;
			end
			S_CMP: begin
				if (!cur_valid && !free_q) begin
					free_n     = 1'b1;
					free_idx_n = ptr_q;
					free_sig_n = rd.sig;
				end
				if (op_q == OP_SWEEP) begin
					if (expired) begin
						valid_n[ptr_q] = 1'b0;
						cnt_n = cnt_q - CW'(1);
						res_n.slot = 4'(ptr_q);
						res_n.hit = 1'b1;
						res_n.peer_device_id = rd.dev;
						res_n.received_count = rd.rx;
						res_n.sent_count = rd.tx;
						res_n.evicted_mac = rd.mac;
						res_n.evicted = 1'b1;
						res_n.last = 1'b0;
						res_load = 1'b1;
						more_n = 1'b1;
						done_n = last_slot;
						state_n = S_OUT;
					end else if (last_slot) begin
						res_load = 1'b1;
						more_n = 1'b0;
						state_n = S_OUT;
					end else begin
						ptr_n = ptr_q + IW'(1);
						state_n = S_RD;
					end
				end else if (match) begin
					res_n.slot = 4'(ptr_q);
					res_n.hit = 1'b1;
					res_n.peer_device_id = rd.dev;
					res_n.received_count = rd.rx;
					res_n.sent_count = rd.tx;
					res_load = 1'b1;
					state_n = S_OUT;
					case (op_q)
						OP_ADD: begin
							ram_we = 1'b1;
							ram_wdata.last_seen = now_q;
						end
						OP_REMOVE: begin
							valid_n[ptr_q] = 1'b0;
							cnt_n = cnt_q - CW'(1);
						end
						OP_SEEN: begin
							ram_we = 1'b1;
							ram_wdata.last_seen = now_q;
							ram_wdata.sig = sig_q;
							ram_wdata.rx = rd.rx + 32'd1;
							res_n.received_count = rd.rx + 32'd1;
						end
						OP_SEND: begin
							ram_we = 1'b1;
							ram_wdata.tx = rd.tx + 32'd1;
							res_n.sent_count = rd.tx + 32'd1;
						end
						default: begin
						end
					endcase
				end else if (last_slot) begin
					res_load = 1'b1;
					state_n = S_OUT;
					if (op_q == OP_ADD) begin
						if (free_n) begin
							ram_we = 1'b1;
							ram_waddr = free_idx_n;
							ram_wdata.mac = mac_q;
							ram_wdata.dev = dev_q;
							ram_wdata.last_seen = now_q;
							ram_wdata.sig = free_sig_n;
							ram_wdata.rx = '0;
							ram_wdata.tx = '0;
							valid_n[free_idx_n] = 1'b1;
							cnt_n = cnt_q + CW'(1);
							res_n.slot = 4'(free_idx_n);
							res_n.hit = 1'b1;
							res_n.peer_device_id = dev_q;
						end else begin
							res_n.status = ST_FULL;
						end
					end else begin
						res_n.status = ST_NOTFOUND;
					end
				end else begin
					ptr_n = ptr_q + IW'(1);
					state_n = S_RD;
				end
			end
			S_OUT: begin
				if (out.ready) begin
					if (!more_q) begin
						state_n = S_IDLE;
					end else if (done_q) begin
						res_load = 1'b1;
						more_n = 1'b0;
					end else begin
						ptr_n = ptr_q + IW'(1);
						state_n = S_RD;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase

		res_n.active_peers = 5'(cnt_n);
		res_n.failure_total = fail_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			enabled_q <= 1'b0;
			timeout_q <= RESET_TIMEOUT;
			valid_q   <= '0;
			cnt_q     <= '0;
			fail_q    <= '0;
			ptr_q     <= '0;
			more_q    <= 1'b0;
			done_q    <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			valid_q <= valid_n;
			cnt_q   <= cnt_n;
			fail_q  <= fail_n;
			ptr_q   <= ptr_n;
			more_q  <= more_n;
			done_q  <= done_n;
			free_q  <= free_n;
			if (cfg_we) begin
				if (cfg_index == REG_ENABLED) begin
					enabled_q <= cfg_wdata[0];
				end else begin
					timeout_q <= cfg_wdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		free_idx_q <= free_idx_n;
		free_sig_q <= free_sig_n;
		if (res_load) begin
			res_q <= res_n;
		end
		if (in.valid && in.ready) begin
			op_q  <= in.operation;
			mac_q <= in.peer_mac;
			dev_q <= in.device_id;
			sig_q <= in.signal_strength;
			now_q <= in.now_ms;
		end
	end

	assign out.valid          = (state_q == S_OUT);
	assign out.status         = res_q.status;
	assign out.slot           = res_q.slot;
	assign out.hit            = res_q.hit;
	assign out.peer_device_id = res_q.peer_device_id;
	assign out.received_count = res_q.received_count;
	assign out.sent_count     = res_q.sent_count;
	assign out.evicted_mac    = res_q.evicted_mac;
	assign out.evicted        = res_q.evicted;
	assign out.active_peers   = res_q.active_peers;
	assign out.failure_total  = res_q.failure_total;
	assign out.last           = res_q.last;

`ifndef ASSERT_OFF
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(valid_q)))
		else $error("Active count disagrees with the valid bits.");
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.evicted |-> out.hit && !out.last)
		else $error("Eviction word is malformed.");
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_CMP)
		else $error("Table write outside the compare step.");
`endif
endmodule

// ===== tb/tb_peer_table_with_aging.sv =====
// Self-checking testbench for the peer table: random operations checked against a table model.
`timescale 1ns / 1ps
module tb_peer_table_with_aging;
	import pta_pkg::*;

	typedef struct {
		logic [2:0]  operation;
		logic [47:0] peer_mac;
		logic [7:0]  device_id;
		logic [7:0]  signal_strength;
		logic        send_ok;
		logic [31:0] now_ms;
	} op_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_wdata = '0;

	pta_in_if in_ch();
	pta_out_if out_ch();

	peer_table_with_aging dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in(in_ch), .out(out_ch)
	);

	always #2 clk = ~clk;

	op_word_t pending_ops[$];
	result_t expected_results[$];
	int error_count = 0;
	int idle_cycles = 0;
	int hold_cycles = 0;
	bit stall_mode = 1'b0;
	bit done = 1'b0;

	// Table model state.
	bit          m_enabled;
	logic [31:0] m_timeout;
	bit          m_valid[16];
	logic [47:0] m_mac[16];
	logic [7:0]  m_dev[16];
	logic [31:0] m_seen[16];
	logic [31:0] m_rx[16];
	logic [31:0] m_tx[16];
	logic [4:0]  m_active;
	logic [31:0] m_failures;
	logic [47:0] mac_pool[8];

	function automatic int find_peer(logic [47:0] mac);
		for (int i = 0; i < 16; i++)
			if (m_valid[i] && m_mac[i] == mac) return i;
		return -1;
	endfunction

	function automatic result_t make_result(logic [1:0] st, int idx, bit ev, bit lst);
		result_t r;
		r = '0;
		r.status = st;
		if (idx >= 0) begin
			r.slot = idx[3:0];
			r.hit = 1'b1;
			r.peer_device_id = m_dev[idx];
			r.received_count = m_rx[idx];
			r.sent_count = m_tx[idx];
			if (ev) begin
				r.evicted_mac = m_mac[idx];
				r.evicted = 1'b1;
			end
		end
		r.active_peers = m_active;
		r.failure_total = m_failures;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_table_op(op_word_t w);
		int idx;
		idx = -1;
		case (w.operation)
			OP_ADD: begin
				if (!m_enabled) begin
					expected_results.push_back(make_result(ST_DISABLED, -1, 0, 1));
				end else begin
					idx = find_peer(w.peer_mac);
					if (idx >= 0) begin
						m_seen[idx] = w.now_ms;
						expected_results.push_back(make_result(ST_OK, idx, 0, 1));
					end else begin
						for (int i = 0; i < 16; i++)
							if (!m_valid[i] && idx < 0) idx = i;
						if (idx < 0) begin
							expected_results.push_back(make_result(ST_FULL, -1, 0, 1));
						end else begin
							m_valid[idx] = 1'b1;
							m_mac[idx] = w.peer_mac;
							m_dev[idx] = w.device_id;
							m_seen[idx] = w.now_ms;
							m_rx[idx] = '0;
							m_tx[idx] = '0;
							m_active++;
							expected_results.push_back(make_result(ST_OK, idx, 0, 1));
						end
					end
				end
			end
			OP_REMOVE: begin
				if (!m_enabled) begin
					expected_results.push_back(make_result(ST_DISABLED, -1, 0, 1));
				end else begin
					idx = find_peer(w.peer_mac);
					if (idx < 0) begin
						expected_results.push_back(make_result(ST_NOTFOUND, -1, 0, 1));
					end else begin
						m_valid[idx] = 1'b0;
						m_active--;
						expected_results.push_back(make_result(ST_OK, idx, 0, 1));
					end
				end
			end
			OP_SEEN: begin
				idx = find_peer(w.peer_mac);
				if (idx < 0) begin
					expected_results.push_back(make_result(ST_NOTFOUND, -1, 0, 1));
				end else begin
					m_seen[idx] = w.now_ms;
					m_rx[idx]++;
					expected_results.push_back(make_result(ST_OK, idx, 0, 1));
				end
			end
			OP_SEND: begin
				if (!w.send_ok) begin
					m_failures++;
					expected_results.push_back(make_result(ST_OK, -1, 0, 1));
				end else begin
					idx = find_peer(w.peer_mac);
					if (idx < 0) begin
						expected_results.push_back(make_result(ST_NOTFOUND, -1, 0, 1));
					end else begin
						m_tx[idx]++;
						expected_results.push_back(make_result(ST_OK, idx, 0, 1));
					end
				end
			end
			OP_SWEEP: begin
				if (!m_enabled) begin
					expected_results.push_back(make_result(ST_DISABLED, -1, 0, 1));
				end else begin
					for (int i = 0; i < 16; i++) begin
						if (m_valid[i] && (w.now_ms - m_seen[i]) > m_timeout) begin
							m_valid[i] = 1'b0;
							m_active--;
							expected_results.push_back(make_result(ST_OK, i, 1, 0));
						end
					end
					expected_results.push_back(make_result(ST_OK, -1, 0, 1));
				end
			end
			OP_LOOKUP: begin
				idx = find_peer(w.peer_mac);
				expected_results.push_back(make_result(idx < 0 ? ST_NOTFOUND : ST_OK, idx,
					0, 1));
			end
			default: expected_results.push_back(make_result(ST_OK, -1, 0, 1));
		endcase
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic write_register(logic idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENABLED) m_enabled = data[0];
		else m_timeout = data;
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic op_word_t make_op(logic [2:0] op, logic [47:0] mac, logic [31:0] now);
		op_word_t w;
		w.operation = op;
		w.peer_mac = mac;
		w.device_id = 8'($urandom_range(0, 255));
		w.signal_strength = 8'($urandom_range(0, 255));
		w.send_ok = 1'($urandom_range(0, 1));
		w.now_ms = now;
		return w;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: offers queued words with random gaps.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.operation <= '0;
			in_ch.peer_mac <= '0;
			in_ch.device_id <= '0;
			in_ch.signal_strength <= '0;
			in_ch.send_ok <= 1'b0;
			in_ch.now_ms <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) predict_table_op('{in_ch.operation, in_ch.peer_mac,
				in_ch.device_id, in_ch.signal_strength, in_ch.send_ok, in_ch.now_ms});
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					op_word_t w;
					w = pending_ops.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.operation <= w.operation;
					in_ch.peer_mac <= w.peer_mac;
					in_ch.device_id <= w.device_id;
					in_ch.signal_strength <= w.signal_strength;
					in_ch.send_ok <= w.send_ok;
					in_ch.now_ms <= w.now_ms;
					send_gap <= gap_length();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure and field-by-field compare.
	int ready_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				result_t got, exp_r;
				got = '{out_ch.status, out_ch.slot, out_ch.hit, out_ch.peer_device_id,
					out_ch.received_count, out_ch.sent_count, out_ch.evicted_mac,
					out_ch.evicted, out_ch.active_peers, out_ch.failure_total, out_ch.last};
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result word");
				end else begin
					exp_r = expected_results.pop_front();
					if (got.status !== exp_r.status) report_mismatch("status");
					if (got.slot !== exp_r.slot) report_mismatch("slot");
					if (got.hit !== exp_r.hit) report_mismatch("hit");
					if (got.peer_device_id !== exp_r.peer_device_id)
						report_mismatch("peer_device_id");
					if (got.received_count !== exp_r.received_count)
						report_mismatch("received_count");
					if (got.sent_count !== exp_r.sent_count) report_mismatch("sent_count");
					if (got.evicted_mac !== exp_r.evicted_mac) report_mismatch("evicted_mac");
					if (got.evicted !== exp_r.evicted) report_mismatch("evicted");
					if (got.active_peers !== exp_r.active_peers)
						report_mismatch("active_peers");
					if (got.failure_total !== exp_r.failure_total)
						report_mismatch("failure_total");
					if (got.last !== exp_r.last) report_mismatch("last");
				end
			end
			if (stall_mode) begin
				out_ch.ready <= 1'b0;
				if (hold_cycles < 400) hold_cycles <= hold_cycles + 1;
				else stall_mode <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap <= ready_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) ready_gap <= gap_length();
			end
		end
	end

	// Watchdog on accepted words.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [31:0] t;
		m_enabled = 0;
		m_timeout = RESET_TIMEOUT;
		m_active = '0;
		m_failures = '0;
		for (int i = 0; i < 16; i++) begin
			m_valid[i] = 0; m_mac[i] = '0; m_dev[i] = '0;
			m_seen[i] = '0; m_rx[i] = '0; m_tx[i] = '0;
		end
		mac_pool[0] = 48'h0;
		mac_pool[1] = 48'hFFFF_FFFF_FFFF;
		mac_pool[2] = 48'hAAAA_AAAA_AAAA;
		mac_pool[3] = 48'h5555_5555_5555;
		for (int i = 4; i < 8; i++) mac_pool[i] = 48'({$urandom(), $urandom()});
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Disabled table: add, remove and sweep are refused, others still work.
		pending_ops.push_back(make_op(OP_ADD, mac_pool[1], 32'd5));
		pending_ops.push_back(make_op(OP_REMOVE, mac_pool[1], 32'd5));
		pending_ops.push_back(make_op(OP_SWEEP, 48'h0, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(OP_LOOKUP, mac_pool[1], 32'd5));
		begin
			op_word_t w;
			w = make_op(OP_SEND, mac_pool[2], 32'd0);
			w.send_ok = 1'b0;
			pending_ops.push_back(w);
			w = make_op(3'd6, mac_pool[2], 32'd0);
			pending_ops.push_back(w);
			w = make_op(3'd7, mac_pool[1], 32'hFFFF_FFFF);
			pending_ops.push_back(w);
		end
		wait_drained();
		write_register(REG_ENABLED, 32'd1);

		// Fill the table past capacity, then touch entries and sweep with wrap.
		for (int i = 0; i < 17; i++)
			pending_ops.push_back(make_op(OP_ADD, (i == 0) ? 48'h0 :
				(i == 1) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom(), $urandom()}),
				32'hFFFF_FF00 + 32'(i)));
		pending_ops.push_back(make_op(OP_ADD, 48'hFFFF_FFFF_FFFF, 32'h0000_0010));
		pending_ops.push_back(make_op(OP_SEEN, 48'h0, 32'd20));
		begin
			op_word_t w;
			w = make_op(OP_SEND, 48'h0, 32'd0);
			w.send_ok = 1'b1;
			pending_ops.push_back(w);
		end
		pending_ops.push_back(make_op(OP_SEEN, 48'h1234, 32'd20));
		pending_ops.push_back(make_op(OP_SWEEP, 48'h0, 32'd30000 + 32'h100));
		wait_drained();

		write_register(REG_TIMEOUT, 32'd0);
		pending_ops.push_back(make_op(OP_SWEEP, 48'h0, 32'd40));
		wait_drained();

		// Receiver holds off while the sender keeps offering words.
		stall_mode = 1'b1;
		for (int i = 0; i < 12; i++)
			pending_ops.push_back(make_op(i % 2 ? OP_LOOKUP : OP_ADD, mac_pool[i % 8],
				32'(i)));
		wait_drained();

		// Random phases across timeout and enable settings.
		t = 32'hFFFF_F000;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_register(REG_TIMEOUT, 32'd50);
				1: write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
				2: write_register(REG_ENABLED, 32'd0);
				3: write_register(REG_ENABLED, 32'd1);
				4: write_register(REG_TIMEOUT, 32'd1);
				default: write_register(REG_TIMEOUT, $urandom_range(0, 400));
			endcase
			for (int n = 0; n < 30; n++) begin
				op_word_t w;
				int r;
				r = $urandom_range(0, 99);
				t = t + $urandom_range(0, 60);
				w = make_op(r < 30 ? OP_ADD : r < 40 ? OP_REMOVE : r < 55 ? OP_SEEN :
					r < 70 ? OP_SEND : r < 80 ? OP_SWEEP : r < 95 ? OP_LOOKUP :
					3'($urandom_range(6, 7)),
					($urandom_range(0, 9) == 0) ? 48'({$urandom(), $urandom()}) :
					mac_pool[$urandom_range(0, 7)], t);
				pending_ops.push_back(w);
			end
			wait_drained();
		end

		done = 1'b1;
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
